// ----- src/epipole_polar_rho_range_assert.svh -----
// Assertion macros for the epipole rho range block.
`ifndef EPIPOLE_POLAR_RHO_RANGE_ASSERT_SVH
`define EPIPOLE_POLAR_RHO_RANGE_ASSERT_SVH
`ifndef SYNTHESIS
`define EPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define EPR_ASSERT(label, clk, rst_n, prop, msg)
`define EPR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ----- src/epr_pkg.sv -----
package epr_pkg;
    localparam int unsigned CORNER_TL = 0;
    localparam int unsigned CORNER_TR = 1;
    localparam int unsigned CORNER_BL = 2;
    localparam int unsigned CORNER_BR = 3;
    localparam logic [3:0] REGION_INSIDE = 4'd4;
    localparam logic [31:0] RHO_MAX = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    // Four 2-bit corner codes packed first..fourth from the top.
    function automatic logic [7:0] corner_codes(input logic [3:0] region);
        logic [7:0] c;
        case (region)
            4'd0:    c = {2'd1, 2'd2, 2'd0, 2'd0};
            4'd1:    c = {2'd1, 2'd0, 2'd0, 2'd0};
            4'd2:    c = {2'd3, 2'd0, 2'd0, 2'd0};
            4'd3:    c = {2'd0, 2'd2, 2'd0, 2'd0};
            4'd4:    c = {2'd0, 2'd1, 2'd3, 2'd2};
            4'd5:    c = {2'd3, 2'd1, 2'd0, 2'd0};
            4'd6:    c = {2'd0, 2'd3, 2'd0, 2'd0};
            4'd7:    c = {2'd2, 2'd3, 2'd0, 2'd0};
            default: c = {2'd2, 2'd1, 2'd0, 2'd0};
        endcase
        return c;
    endfunction
endpackage

// ----- src/epr_front.sv -----
module epr_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                camera,
    input  logic signed [31:0]  epipole_x,
    input  logic signed [31:0]  epipole_y,
    input  logic [15:0]         image_width,
    input  logic [15:0]         image_height,
    output logic                q_valid,
    input  logic                q_ready,
    output logic                q_camera,
    output logic [3:0]          q_region,
    output logic [33:0]         q_dx0,
    output logic [33:0]         q_dx1,
    output logic [33:0]         q_dy0,
    output logic [33:0]         q_dy1
);
    import epr_pkg::*;

    localparam int EW = 34;
    localparam int DEPTH = 2;

    logic signed [EW-1:0] x, y, right, bottom, rdx, bdy;
    logic [1:0] row, col;
    logic [3:0] region;
    logic [1+4+4*EW-1:0] wdata, mem_reg [DEPTH];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign x = EW'(epipole_x);
    assign y = EW'(epipole_y);
    assign right  = (EW'($signed({1'b0, image_width}))  - EW'(1)) <<< FRACTION_BITS;
    assign bottom = (EW'($signed({1'b0, image_height})) - EW'(1)) <<< FRACTION_BITS;
    assign rdx = right - x;
    assign bdy = bottom - y;
    assign row = y[EW-1] ? 2'd0 : ((y <= bottom) ? 2'd1 : 2'd2);
    assign col = x[EW-1] ? 2'd0 : ((x <= right) ? 2'd1 : 2'd2);
    assign region = 4'(row) * 4'd3 + 4'(col);
    assign wdata = {camera, region, x, rdx, y, bdy};

    assign in_ready = cnt_reg != 2'(DEPTH);
    assign q_valid = cnt_reg != 2'd0;
    assign {q_camera, q_region, q_dx0, q_dx1, q_dy0, q_dy1} = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end
endmodule

// ----- src/epr_back.sv -----
module epr_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  logic         q_camera,
    input  logic [3:0]   q_region,
    input  logic [33:0]  q_dx0,
    input  logic [33:0]  q_dx1,
    input  logic [33:0]  q_dy0,
    input  logic [33:0]  q_dy1,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         camera_echo,
    output logic [3:0]   region,
    output logic [2:0]   corner_count,
    output logic [1:0]   corner_first,
    output logic [1:0]   corner_second,
    output logic [1:0]   corner_third,
    output logic [1:0]   corner_fourth,
    output logic [31:0]  min_rho,
    output logic [31:0]  max_rho
);
    import epr_pkg::*;

    `include "epipole_polar_rho_range_assert.svh"

    // Stages: 0 magnitudes, 1 squares, 2 sums, 3..34 root steps, 35 select.
    localparam int NS = 36;
    localparam int RS = 32;

    logic [NS-1:0] v_reg;
    logic adv;
    logic [NS-1:0] stall;

    logic [33:0] ax_reg [2], ay_reg [2];
    logic [33:0] ex_reg;
    logic [3:0] rg_reg [NS];
    logic cam_reg [NS];
    logic [31:0] edge_reg [NS];
    logic [3:0] ovf_reg [NS];
    logic [63:0] sq_x_reg [2], sq_y_reg [2];
    logic [64:0] n_reg [RS+1][4];
    logic [31:0] r_reg [RS+1][4];

    logic [33:0] qx[2], qy[2];
    logic [33:0] edge_mag;
    logic [33:0] edge_val;
    logic [3:0] ovf0;
    logic [31:0] d[4], mn, mx;

    function automatic logic [33:0] mag34(input logic [33:0] v);
        return v[33] ? (34'd0 - v) : v;
    endfunction

    assign qx[0] = mag34(q_dx0);
    assign qx[1] = mag34(q_dx1);
    assign qy[0] = mag34(q_dy0);
    assign qy[1] = mag34(q_dy1);

    always_comb
    begin
        case (q_region)
            4'd1:    edge_val = 34'd0 - q_dy0;
            4'd3:    edge_val = 34'd0 - q_dx0;
            4'd5:    edge_val = 34'd0 - q_dx1;
            4'd7:    edge_val = 34'd0 - q_dy1;
            default: edge_val = 34'd0;
        endcase
    end
    assign edge_mag = mag34(edge_val);

    // Corner k uses x offset k[0] and y offset k[1].
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ovf0[k] = (qx[k%2][33:32] != 2'd0) || (qy[k/2][33:32] != 2'd0);
        end
    end

    // A full pipeline stalls when the output holds; bubbles collapse.
    always_comb
    begin
        stall[NS-1] = v_reg[NS-1] && out_valid && !out_ready;
        for (int s = NS-2; s >= 0; s--)
        begin
            stall[s] = v_reg[s] && stall[s+1];
        end
    end
    assign adv = !stall[NS-1];
    assign q_ready = !stall[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (!stall[0])
            begin
                v_reg[0] <= q_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (!stall[s])
                begin
                    v_reg[s] <= v_reg[s-1] && !stall[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall[0])
        begin
            ax_reg[0] <= qx[0];
            ax_reg[1] <= qx[1];
            ay_reg[0] <= qy[0];
            ay_reg[1] <= qy[1];
            rg_reg[0] <= q_region;
            cam_reg[0] <= q_camera;
            ex_reg <= edge_mag;
            ovf_reg[0] <= ovf0;
        end
        if (!stall[1])
        begin
            for (int i = 0; i < 2; i++)
            begin
                sq_x_reg[i] <= ax_reg[i][31:0] * ax_reg[i][31:0];
                sq_y_reg[i] <= ay_reg[i][31:0] * ay_reg[i][31:0];
            end
            rg_reg[1] <= rg_reg[0];
            cam_reg[1] <= cam_reg[0];
            ovf_reg[1] <= ovf_reg[0];
            edge_reg[1] <= (ex_reg[33:32] != 2'd0) ? RHO_MAX : ex_reg[31:0];
        end
        if (!stall[2])
        begin
            for (int k = 0; k < 4; k++)
            begin
                n_reg[0][k] <= {1'b0, sq_x_reg[k%2]} + {1'b0, sq_y_reg[k/2]};
                r_reg[0][k] <= '0;
            end
            rg_reg[2] <= rg_reg[1];
            cam_reg[2] <= cam_reg[1];
            ovf_reg[2] <= ovf_reg[1];
            edge_reg[2] <= edge_reg[1];
        end
        for (int s = 3; s < NS; s++)
        begin
            if (!stall[s])
            begin
                rg_reg[s] <= rg_reg[s-1];
                cam_reg[s] <= cam_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                edge_reg[s] <= edge_reg[s-1];
            end
        end
        // One result bit per stage; the sum in n is reduced as it moves down the stages.
        for (int s = 0; s < RS; s++)
        begin
            if (!stall[s+3])
            begin
                for (int k = 0; k < 4; k++)
                begin
                    logic [66:0] trial;
                    logic [66:0] rem;
                    trial = ({35'd0, r_reg[s][k]} << (RS-s))
                        + (67'd1 << (2*(RS-1-s)));
                    rem = {2'b0, n_reg[s][k]};
                    if (rem >= trial)
                    begin
                        n_reg[s+1][k] <= 65'(rem - trial);
                        r_reg[s+1][k] <= r_reg[s][k] | (32'd1 << (RS-1-s));
                    end
                    else
                    begin
                        n_reg[s+1][k] <= n_reg[s][k];
                        r_reg[s+1][k] <= r_reg[s][k];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            d[k] = ovf_reg[NS-2][k] ? RHO_MAX : r_reg[RS][k];
        end
        case (rg_reg[NS-2])
            4'd0:    begin mn = d[0]; mx = d[3]; end
            4'd1:    begin mn = edge_reg[NS-2]; mx = (d[2] > d[3]) ? d[2] : d[3]; end
            4'd2:    begin mn = d[1]; mx = d[2]; end
            4'd3:    begin mn = edge_reg[NS-2]; mx = (d[3] > d[1]) ? d[3] : d[1]; end
            4'd4:
            begin
                mn = '0;
                mx = (d[0] > d[1]) ? d[0] : d[1];
                mx = (d[2] > mx) ? d[2] : mx;
                mx = (d[3] > mx) ? d[3] : mx;
            end
            4'd5:    begin mn = edge_reg[NS-2]; mx = (d[0] > d[2]) ? d[0] : d[2]; end
            4'd6:    begin mn = d[2]; mx = d[1]; end
            4'd7:    begin mn = edge_reg[NS-2]; mx = (d[0] > d[1]) ? d[0] : d[1]; end
            default: begin mn = d[3]; mx = d[0]; end
        endcase
    end

    logic [31:0] mn_reg, mx_reg;
    logic [7:0] cc_reg;

    always_ff @(posedge clk)
    begin
        if (!stall[NS-1])
        begin
            mn_reg <= mn;
            mx_reg <= mx;
            cc_reg <= corner_codes(rg_reg[NS-2]);
        end
    end

    assign out_valid = v_reg[NS-1];
    assign camera_echo = cam_reg[NS-1];
    assign region = rg_reg[NS-1];
    assign corner_count = (rg_reg[NS-1] == REGION_INSIDE) ? 3'd4 : 3'd2;
    assign {corner_first, corner_second, corner_third, corner_fourth} = cc_reg;
    assign min_rho = mn_reg;
    assign max_rho = mx_reg;

    `EPR_ASSERT(a_region_range, clk, rst_n, out_valid |-> region <= 4'd8, "region out of range")
    `EPR_ASSERT(a_inside_min, clk, rst_n, (out_valid && region == REGION_INSIDE) |-> min_rho == 32'd0, "inside min not zero")
    `EPR_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(max_rho), "result dropped")
endmodule

// ----- src/epipole_polar_rho_range.sv -----
// Epipole polar rho range.
// Input channel (in_valid/in_ready) takes one epipole item: camera tag and
// signed fixed point x, y. Output channel (out_valid/out_ready) gives one
// result item per input: region, extreme corners, min and max distance.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// image_width (index 0) and image_height (index 1); always ready.
// An accepted item waits in the two-entry classify queue, then enters a
// 36-stage pipeline whose first stage loads as the item leaves the queue;
// 32 stages are the bit-per-stage square root of four corner distances in
// parallel. Throughput is one item per cycle when out_ready is high.
// Reset sets width 640, height 480 and empties queue and pipeline.
// When the receiver stalls the pipeline fills its empty slots, then the
// queue fills, then in_ready drops; no item is lost.
module epipole_polar_rho_range #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               camera,
    input  logic signed [31:0] epipole_x,
    input  logic signed [31:0] epipole_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               camera_echo,
    output logic [3:0]         region,
    output logic [2:0]         corner_count,
    output logic [1:0]         corner_first,
    output logic [1:0]         corner_second,
    output logic [1:0]         corner_third,
    output logic [1:0]         corner_fourth,
    output logic [31:0]        min_rho,
    output logic [31:0]        max_rho
);
    import epr_pkg::*;

    logic [15:0] width_reg, height_reg;
    logic q_valid, q_ready, q_camera;
    logic [3:0] q_region;
    logic [33:0] q_dx0, q_dx1, q_dy0, q_dy1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 16'd640;
            height_reg <= 16'd480;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WIDTH:  width_reg <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    epr_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .camera, .epipole_x, .epipole_y,
        .image_width(width_reg), .image_height(height_reg),
        .q_valid, .q_ready, .q_camera, .q_region, .q_dx0, .q_dx1, .q_dy0, .q_dy1
    );

    epr_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_camera, .q_region,
        .q_dx0, .q_dx1, .q_dy0, .q_dy1,
        .out_valid, .out_ready, .camera_echo, .region, .corner_count,
        .corner_first, .corner_second, .corner_third, .corner_fourth,
        .min_rho, .max_rho
    );
endmodule

// ----- test/testbench.sv -----
module testbench;
    import epr_pkg::*;

    localparam int FRAC = 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic        camera;
        logic [31:0] ex;
        logic [31:0] ey;
    } epipole_t;

    typedef struct {
        logic        camera;
        logic [3:0]  reg_id;
        logic [2:0]  count;
        logic [1:0]  c0, c1, c2, c3;
        logic [31:0] rho_lo;
        logic [31:0] rho_hi;
    } rho_range_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic camera = 1'b0;
    logic signed [31:0] epipole_x = '0;
    logic signed [31:0] epipole_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_WIDTH;
    logic [15:0] cfg_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic camera_echo;
    logic [3:0] region;
    logic [2:0] corner_count;
    logic [1:0] corner_first, corner_second, corner_third, corner_fourth;
    logic [31:0] min_rho, max_rho;

    epipole_t   pending_epipoles[$];
    rho_range_t expected_ranges[$];
    logic [15:0] img_w = 16'd640;
    logic [15:0] img_h = 16'd480;
    int  errors = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 0;
    bit  quiet = 0;
    int  region_hits[9];

    epipole_polar_rho_range u_top (.*);

    always #1 clk = ~clk;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [31:0] sat_abs(input logic signed [63:0] v);
        logic [63:0] m;
        m = abs64(v);
        return m > 64'hFFFF_FFFF ? RHO_MAX : m[31:0];
    endfunction

    function automatic logic [31:0] corner_rho(input logic signed [63:0] dx,
                                               input logic signed [63:0] dy);
        logic [63:0] ax, ay, trial, root, n;
        logic [64:0] s;
        ax = abs64(dx);
        ay = abs64(dy);
        if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF)
            return RHO_MAX;
        s = {1'b0, ax * ax} + {1'b0, ay * ay};
        if (s[64])
            return RHO_MAX;
        n = s[63:0];
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n)
                root = trial;
        end
        return root[31:0];
    endfunction

    function automatic logic [31:0] umax(input logic [31:0] a, input logic [31:0] b);
        return a > b ? a : b;
    endfunction

    function automatic rho_range_t predict_range(input epipole_t e);
        rho_range_t r;
        logic signed [63:0] x, y, rt, bt;
        logic [31:0] da, db, dc, dd;
        int row, col;
        x = 64'(signed'(e.ex));
        y = 64'(signed'(e.ey));
        rt = (64'(img_w) - 1) <<< FRAC;
        bt = (64'(img_h) - 1) <<< FRAC;
        row = y < 0 ? 0 : (y <= bt ? 1 : 2);
        col = x < 0 ? 0 : (x <= rt ? 1 : 2);
        da = corner_rho(x, y);
        db = corner_rho(rt - x, y);
        dc = corner_rho(x, bt - y);
        dd = corner_rho(rt - x, bt - y);
        r.camera = e.camera;
        r.reg_id = 4'(row * 3 + col);
        r.count = r.reg_id == REGION_INSIDE ? 3'd4 : 3'd2;
        r.c2 = 2'(CORNER_TL);
        r.c3 = 2'(CORNER_TL);
        case (r.reg_id)
            4'd0:
            begin
                r.rho_lo = da; r.rho_hi = dd;
                r.c0 = 2'(CORNER_TR); r.c1 = 2'(CORNER_BL);
            end
            4'd1:
            begin
                r.rho_lo = sat_abs(-y); r.rho_hi = umax(dc, dd);
                r.c0 = 2'(CORNER_TR); r.c1 = 2'(CORNER_TL);
            end
            4'd2:
            begin
                r.rho_lo = db; r.rho_hi = dc;
                r.c0 = 2'(CORNER_BR); r.c1 = 2'(CORNER_TL);
            end
            4'd3:
            begin
                r.rho_lo = sat_abs(-x); r.rho_hi = umax(dd, db);
                r.c0 = 2'(CORNER_TL); r.c1 = 2'(CORNER_BL);
            end
            REGION_INSIDE:
            begin
                r.rho_lo = 0; r.rho_hi = umax(umax(da, db), umax(dc, dd));
                r.c0 = 2'(CORNER_TL); r.c1 = 2'(CORNER_TR);
                r.c2 = 2'(CORNER_BR); r.c3 = 2'(CORNER_BL);
            end
            4'd5:
            begin
                r.rho_lo = sat_abs(x - rt); r.rho_hi = umax(da, dc);
                r.c0 = 2'(CORNER_BR); r.c1 = 2'(CORNER_TR);
            end
            4'd6:
            begin
                r.rho_lo = dc; r.rho_hi = db;
                r.c0 = 2'(CORNER_TL); r.c1 = 2'(CORNER_BR);
            end
            4'd7:
            begin
                r.rho_lo = sat_abs(y - bt); r.rho_hi = umax(da, db);
                r.c0 = 2'(CORNER_BL); r.c1 = 2'(CORNER_BR);
            end
            default:
            begin
                r.rho_lo = dd; r.rho_hi = da;
                r.c0 = 2'(CORNER_BL); r.c1 = 2'(CORNER_TR);
            end
        endcase
        return r;
    endfunction

    // Driver: hold the item until accepted, then advance or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                epipole_t e;
                rho_range_t r;
                e.camera = camera;
                e.ex = epipole_x;
                e.ey = epipole_y;
                r = predict_range(e);
                expected_ranges.push_back(r);
                region_hits[r.reg_id]++;
                n_accepted++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left == 0 && !quiet && $urandom_range(0, 11) == 0)
                    gap_left = $urandom_range(1, 17);
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_epipoles.size() > 0)
                begin
                    epipole_t e;
                    e = pending_epipoles.pop_front();
                    in_valid <= 1'b1;
                    camera <= e.camera;
                    epipole_x <= e.ex;
                    epipole_y <= e.ey;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: compare each item, stall the receiver in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ranges.size() == 0)
                begin
                    errors++;
                    $display("%0t: result item with none expected", $time);
                end
                else
                begin
                    rho_range_t r;
                    r = expected_ranges.pop_front();
                    check_field("camera_echo", r.camera, camera_echo);
                    check_field("region", r.reg_id, region);
                    check_field("corner_count", r.count, corner_count);
                    check_field("corner_first", r.c0, corner_first);
                    check_field("corner_second", r.c1, corner_second);
                    check_field("corner_third", r.c2, corner_third);
                    check_field("corner_fourth", r.c3, corner_fourth);
                    check_field("min_rho", r.rho_lo, min_rho);
                    check_field("max_rho", r.rho_hi, max_rho);
                    n_checked++;
                end
            end
            if (hold_left == 0 && !long_hold_done && n_accepted >= 100)
            begin
                long_hold_done = 1;
                hold_left = 300;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 11) == 0)
            begin
                hold_left = $urandom_range(1, 17);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH)
            img_w = value;
        else
            img_h = value;
    endtask

    // Count consecutive edges with nothing queued, offered or in flight.
    task automatic wait_idle();
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < DRAIN_CYCLES)
        begin
            @(posedge clk);
            if (pending_epipoles.size() == 0 && expected_ranges.size() == 0 && !in_valid)
                idle_cycles++;
            else
                idle_cycles = 0;
        end
    endtask

    task automatic queue_epipole(input logic signed [31:0] x, input logic signed [31:0] y);
        epipole_t e;
        e.camera = 1'($urandom_range(0, 1));
        e.ex = x;
        e.ey = y;
        pending_epipoles.push_back(e);
    endtask

    // Mostly near the image so all regions and edges show up, some full range.
    function automatic logic signed [31:0] rand_coord(input logic [15:0] extent);
        int sel;
        int signed span;
        sel = $urandom_range(0, 9);
        span = (int'(extent) + 8) * 256;
        if (sel < 6)
            return $urandom_range(0, 3 * span) - span;
        else if (sel == 6)
            return (int'(extent) - 1) * 256 + $urandom_range(0, 2) - 1;
        else if (sel == 7)
            return $urandom_range(0, 2) - 1;
        else
            return $urandom;
    endfunction

    initial
    begin
        logic [15:0] widths[5];
        logic [15:0] heights[5];
        widths = '{16'd640, 16'd1, 16'd65535, 16'd0, 16'd320};
        heights = '{16'd480, 16'd65535, 16'd1, 16'd0, 16'd200};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 5; p++)
        begin
            int signed rt, bt;
            wait_idle();
            if (p == 4)
            begin
                widths[p] = 16'($urandom_range(2, 4000));
                heights[p] = 16'($urandom_range(2, 4000));
                quiet = 1;
            end
            write_reg(CFG_WIDTH, widths[p]);
            write_reg(CFG_HEIGHT, heights[p]);
            rt = (int'(img_w) - 1) * 256;
            bt = (int'(img_h) - 1) * 256;
            // Corners, edges, just outside each edge, inside, extremes.
            queue_epipole(0, 0);
            queue_epipole(rt, bt);
            queue_epipole(rt, 0);
            queue_epipole(0, bt);
            queue_epipole(-1, -1);
            queue_epipole(rt / 2, -1);
            queue_epipole(rt + 1, -1);
            queue_epipole(-1, bt / 2);
            queue_epipole(rt / 2, bt / 2);
            queue_epipole(rt + 1, bt / 2);
            queue_epipole(-1, bt + 1);
            queue_epipole(rt / 2, bt + 1);
            queue_epipole(rt + 1, bt + 1);
            queue_epipole(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
            queue_epipole(32'sh8000_0000, 32'sh8000_0000);
            queue_epipole(32'sh8000_0000, 32'sh7FFF_FFFF);
            queue_epipole(32'sh7FFF_FFFF, 32'sh8000_0000);
            queue_epipole(32'sh8000_0000, bt / 2);
            queue_epipole(rt / 2, 32'sh7FFF_FFFF);
            for (int i = 0; i < 300; i++)
                queue_epipole(rand_coord(img_w), rand_coord(img_h));
        end
        wait_idle();
        $display("Checked %0d of %0d items over five image sizes incl. zero and 65535",
                 n_checked, n_accepted);
        $display("Region hits: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 region_hits[0], region_hits[1], region_hits[2], region_hits[3],
                 region_hits[4], region_hits[5], region_hits[6], region_hits[7],
                 region_hits[8]);
        if (errors == 0 && expected_ranges.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- epipole_polar_rho_range.f -----
+incdir+src
src/epr_pkg.sv
src/epr_front.sv
src/epr_back.sv
src/epipole_polar_rho_range.sv
test/testbench.sv
